/* rtl/kbe_pkg.sv */
// shared types, constants and key translation tables of the keyboard encoder
package kbe_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QS_W = QC_W + 1;

    // field widths
    localparam int ACT_W    = 2;
    localparam int KEY_W    = 8;
    localparam int CODE_W   = 9;
    localparam int SW_W     = 4;
    localparam int DATA_W   = 8;
    localparam int PHASE_W  = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [KEY_W-1:0]  key_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_KEY_DOWN = 2'd0,
        ACT_KEY_UP   = 2'd1,
        ACT_TICK     = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // special host key codes
    localparam key_t KEY_BREAK = 8'h13;
    localparam key_t KEY_CAPS  = 8'h14;
    localparam key_t KEY_KANA  = 8'h15;
    localparam key_t KEY_F1    = 8'h70;
    localparam key_t KEY_F4    = 8'h73;
    localparam key_t CTRL_LO   = 8'h40;
    localparam key_t CTRL_HI   = 8'h5f;
    localparam code_t CTRL_OFS = 9'h040;
    localparam code_t SHIFT_BIT = 9'h100;
    localparam code_t KANA_BIT  = 9'h080;

    // frame sequence phases
    localparam logic [PHASE_W-1:0] PH_POP    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_STB_HI = 3'd1;
    localparam logic [PHASE_W-1:0] PH_STB_LO = 3'd2;
    localparam logic [PHASE_W-1:0] PH_LAST   = 3'd5;

    // control and cursor keys, shared by all tables (kana sets bit 7)
    function automatic code_t ctl_code(input key_t key);
        code_t c;
        c = '0;
        case (key)
            8'h08: c = 9'h008;
            8'h09: c = 9'h009;
            8'h0d: c = 9'h00a;
            8'h12: c = 9'h061;
            8'h1b: c = 9'h01b;
            8'h20: c = 9'h020;
            8'h24: c = 9'h063;
            8'h25: c = 9'h175;
            8'h26: c = 9'h066;
            8'h27: c = 9'h075;
            8'h28: c = 9'h166;
            8'h2d: c = 9'h064;
            8'h2e: c = 9'h164;
            default: c = '0;
        endcase
        return c;
    endfunction

    // numeric keypad, same in all tables
    function automatic code_t pad_code(input key_t key);
        code_t c;
        c = '0;
        case (key)
            8'h6a: c = 9'h02a;
            8'h6b: c = 9'h02b;
            8'h6d: c = 9'h02d;
            8'h6e: c = 9'h02e;
            8'h6f: c = 9'h02f;
            default: begin
                if (key >= 8'h60 && key <= 8'h69) begin
                    c = code_t'(key) - 9'h030;
                end
            end
        endcase
        return c;
    endfunction

    function automatic code_t plain_code(input key_t key);
        code_t c;
        c = '0;
        case (key)
            8'hba: c = 9'h03a;
            8'hbb: c = 9'h03b;
            8'hbc: c = 9'h02c;
            8'hbd: c = 9'h02d;
            8'hbe: c = 9'h02e;
            8'hbf: c = 9'h02f;
            8'hc0: c = 9'h040;
            8'hdb: c = 9'h05b;
            8'hdc: c = 9'h05c;
            8'hdd: c = 9'h05d;
            8'hde: c = 9'h05e;
            8'he2: c = 9'h05f;
            default: begin
                if ((key >= 8'h30 && key <= 8'h39) || (key >= 8'h41 && key <= 8'h5a)) begin
                    c = code_t'(key);
                end
            end
        endcase
        return c;
    endfunction

    function automatic code_t shift_code(input key_t key);
        code_t c;
        c = '0;
        case (key)
            8'hba: c = 9'h02a;
            8'hbb: c = 9'h02b;
            8'hbc: c = 9'h03c;
            8'hbd: c = 9'h03d;
            8'hbe: c = 9'h03e;
            8'hbf: c = 9'h02f;
            8'he2: c = 9'h05f;
            default: begin
                if (key >= 8'h31 && key <= 8'h39) begin
                    c = code_t'(key) - 9'h010;
                end else if (key >= 8'h41 && key <= 8'h5a) begin
                    c = code_t'(key);
                end
            end
        endcase
        return c;
    endfunction

    function automatic code_t kana_code(input key_t key);
        code_t c;
        c = '0;
        case (key)
            8'h30: c = 9'h0dc;  8'h31: c = 9'h0c7;  8'h32: c = 9'h0cc;  8'h33: c = 9'h0b1;
            8'h34: c = 9'h0b3;  8'h35: c = 9'h0b4;  8'h36: c = 9'h0b5;  8'h37: c = 9'h0d4;
            8'h38: c = 9'h0d5;  8'h39: c = 9'h0d6;
            8'h41: c = 9'h0c1;  8'h42: c = 9'h0ba;  8'h43: c = 9'h0bf;  8'h44: c = 9'h0bc;
            8'h45: c = 9'h0b2;  8'h46: c = 9'h0ca;  8'h47: c = 9'h0b7;  8'h48: c = 9'h0b8;
            8'h49: c = 9'h0c6;  8'h4a: c = 9'h0cf;  8'h4b: c = 9'h0c9;  8'h4c: c = 9'h0d8;
            8'h4d: c = 9'h0d3;  8'h4e: c = 9'h0d0;  8'h4f: c = 9'h0d7;
            8'h50: c = 9'h0be;  8'h51: c = 9'h0c0;  8'h52: c = 9'h0bd;  8'h53: c = 9'h0c4;
            8'h54: c = 9'h0b6;  8'h55: c = 9'h0c5;  8'h56: c = 9'h0cb;  8'h57: c = 9'h0c3;
            8'h58: c = 9'h0bb;  8'h59: c = 9'h0dd;  8'h5a: c = 9'h0c2;
            8'hba: c = 9'h0b9;  8'hbb: c = 9'h0da;  8'hbc: c = 9'h0c8;  8'hbd: c = 9'h0ce;
            8'hbe: c = 9'h0d9;  8'hbf: c = 9'h0d2;  8'hc0: c = 9'h0de;
            8'hdb: c = 9'h0df;  8'hdc: c = 9'h0b0;  8'hdd: c = 9'h0d1;  8'hde: c = 9'h0cd;
            8'he2: c = 9'h0db;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic code_t kana_shift_code(input key_t key);
        code_t c;
        c = '0;
        case (key)
            8'h30: c = 9'h0a6;  8'h33: c = 9'h0a7;  8'h34: c = 9'h0a9;  8'h35: c = 9'h0aa;
            8'h36: c = 9'h0ab;  8'h37: c = 9'h0ac;  8'h38: c = 9'h0ad;  8'h39: c = 9'h0ae;
            8'h45: c = 9'h0a8;  8'h5a: c = 9'h0af;
            8'hbc: c = 9'h0a4;  8'hbe: c = 9'h0a1;  8'hbf: c = 9'h0a5;
            8'hdb: c = 9'h0a2;  8'hdd: c = 9'h0a3;
            default: c = '0;
        endcase
        return c;
    endfunction

    // full translation of a key-down, shift flag in bit 8
    function automatic code_t translate(input key_t key, input logic kana,
                                        input logic shift, input logic ctrl);
        code_t c;
        code_t ctl;
        logic  ctrl_range;
        ctl = ctl_code(key);
        ctrl_range = ctrl && key >= CTRL_LO && key <= CTRL_HI;
        if (ctrl_range) begin
            c = kana ? code_t'(key) + CTRL_OFS : code_t'(key) - CTRL_OFS;
        end else if (ctl != '0) begin
            c = kana ? (ctl | KANA_BIT) : ctl;
        end else begin
            case ({kana, shift})
                2'b00:   c = plain_code(key);
                2'b01:   c = shift_code(key);
                2'b10:   c = kana_code(key);
                2'b11:   c = kana_shift_code(key);
                default: c = '0;
            endcase
            c = c | pad_code(key);
        end
        if (shift) begin
            c = c | SHIFT_BIT;
        end
        return c;
    endfunction

endpackage

/* rtl/keyboard_encoder_with_strobe.sv */
// keyboard encoder top level: key translation, code queue and strobe sequence
//
// Takes one beat per clock and returns exactly one result beat per input beat, so
// it sustains one item per cycle while m_tready stays high; a result is held in the
// output register and the input side keeps taking beats as long as that register
// is empty or being drained. Translated key codes are kept in a QUEUE_DEPTH-entry
// memory with one write and one registered read port; the read port prefetches
// the entry at the next queue head every cycle, with a bypass for a code written
// to that same entry, so a frame tick can pop in the cycle it arrives. The memory
// needs no clearing after reset: an entry is only used after it was written.
module keyboard_encoder_with_strobe (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] host_key, [8] shift_held, [9] ctrl_held, rest zero
    input  logic [kbe_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] action
    input  logic [kbe_pkg::ACT_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] nmi_pulse, [4:1] switch_lines, [12:5] data_byte, [13] strobe_res,
    // [14] shift_line, [15] queue_dropped
    output logic [kbe_pkg::M_DATA_W-1:0]  m_tdata
);
    import kbe_pkg::*;

    // code queue memory and its prefetch path
    code_t             queue_mem [QUEUE_DEPTH];
    code_t             rd_data_reg;
    code_t             byp_data_reg;
    logic              byp_reg;
    logic [QA_W-1:0]   rd_addr;
    logic              wr_en;
    logic [QA_W-1:0]   wr_addr;
    code_t             wr_data;
    code_t             head_data;

    // control state
    logic [QC_W-1:0]    count_reg,   count_next;
    logic [QA_W-1:0]    head_reg,    head_next;
    code_t              cur_reg,     cur_next;
    logic [PHASE_W-1:0] phase_reg,   phase_next;
    logic               kana_reg,    kana_next;
    logic [SW_W-1:0]    switch_reg,  switch_next;
    logic [DATA_W-1:0]  data_reg,    data_next;
    logic               strobe_reg,  strobe_next;
    logic               shift_reg,   shift_next;
    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    // beat fields
    action_t            act;
    key_t               key;
    logic               in_shift;
    logic               in_ctrl;
    logic               accept;
    logic               nmi;
    logic               dropped;
    code_t              code;
    logic [QS_W-1:0]    tail_sum;
    logic [1:0]         fkey;
    logic               is_fkey;

    assign act      = action_t'(s_tuser);
    assign key      = s_tdata[KEY_W-1:0];
    assign in_shift = s_tdata[KEY_W];
    assign in_ctrl  = s_tdata[KEY_W+1];
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_fkey  = key >= KEY_F1 && key <= KEY_F4;
    assign fkey     = 2'(key - KEY_F1);
    assign code     = translate(key, kana_reg, in_shift, in_ctrl);
    assign head_data = byp_reg ? byp_data_reg : rd_data_reg;

    // tail slot of the queue
    always_comb begin
        tail_sum = QS_W'(head_reg) + QS_W'(count_reg);
        if (tail_sum >= QS_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - QS_W'(QUEUE_DEPTH);
        end
    end
    assign wr_addr = tail_sum[QA_W-1:0];
    assign wr_data = code;

    // item processing
    always_comb begin
        count_next  = count_reg;
        head_next   = head_reg;
        cur_next    = cur_reg;
        phase_next  = phase_reg;
        kana_next   = kana_reg;
        switch_next = switch_reg;
        data_next   = data_reg;
        strobe_next = strobe_reg;
        shift_next  = shift_reg;
        nmi         = 1'b0;
        dropped     = 1'b0;
        wr_en       = 1'b0;
        case (act)
            ACT_KEY_DOWN: begin
                if (key == KEY_BREAK) begin
                    nmi = 1'b1;
                end else if (key == KEY_CAPS) begin
                    kana_next = 1'b0;
                end else if (key == KEY_KANA) begin
                    kana_next = !kana_reg;
                end else if (is_fkey) begin
                    switch_next[fkey] = 1'b0;
                end else if (code != '0) begin
                    if (count_reg == QC_W'(QUEUE_DEPTH)) begin
                        dropped = 1'b1;
                    end else begin
                        wr_en      = accept;
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ACT_KEY_UP: begin
                if (is_fkey) begin
                    switch_next[fkey] = 1'b1;
                end
            end
            ACT_TICK: begin
                case (phase_reg)
                    PH_POP: begin
                        if (count_reg == '0) begin
                            cur_next = '0;
                        end else begin
                            cur_next   = head_data;
                            count_next = count_reg - 1'b1;
                            head_next  = (head_reg == QA_W'(QUEUE_DEPTH - 1)) ?
                                         '0 : head_reg + 1'b1;
                        end
                        if (cur_next != '0) begin
                            shift_next = cur_next[CODE_W-1];
                            if (cur_next[DATA_W-1:0] != '0) begin
                                data_next = cur_next[DATA_W-1:0];
                            end
                        end
                    end
                    PH_STB_HI: begin
                        if (cur_reg[DATA_W-1:0] != '0) begin
                            strobe_next = 1'b1;
                        end
                    end
                    PH_STB_LO: begin
                        if (cur_reg[DATA_W-1:0] != '0) begin
                            strobe_next = 1'b0;
                        end
                    end
                    default: ;
                endcase
                phase_next = (phase_reg >= PH_LAST) ? '0 : phase_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // prefetch follows the head that the next beat will see
    assign rd_addr = (!aresetn) ? '0 : (accept ? head_next : head_reg);

    // queue memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            queue_mem[wr_addr] <= wr_data;
        end
        rd_data_reg  <= queue_mem[rd_addr];
        byp_reg      <= wr_en && (wr_addr == rd_addr);
        byp_data_reg <= wr_data;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            head_reg    <= '0;
            cur_reg     <= '0;
            phase_reg   <= '0;
            kana_reg    <= 1'b0;
            switch_reg  <= '1;
            data_reg    <= '0;
            strobe_reg  <= 1'b0;
            shift_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg  <= count_next;
                head_reg   <= head_next;
                cur_reg    <= cur_next;
                phase_reg  <= phase_next;
                kana_reg   <= kana_next;
                switch_reg <= switch_next;
                data_reg   <= data_next;
                strobe_reg <= strobe_next;
                shift_reg  <= shift_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result beat register
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {dropped, shift_next, strobe_next, data_next, switch_next, nmi};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

/* verif/keyboard_encoder_with_strobe_tb.sv */
// self-checking testbench for the keyboard encoder: key events and frame ticks checked beat by beat
module keyboard_encoder_with_strobe_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kbe_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 60;
    localparam int RANDOM_ITEMS  = 580;
    localparam int IDLE_PCT      = 24;
    localparam int SETTLE_CYCLES = 10;

    // one result beat, laid out as on m_tdata (msb first)
    typedef struct packed {
        logic       dropped;
        logic       shift_line;
        logic       strobe;
        logic [7:0] data_byte;
        logic [3:0] switch_lines;
        logic       nmi;
    } encoder_lines_t;

    // mirrors the encoder state and keeps the expected output lines
    class key_encoder_scoreboard;
        code_t          held_codes[QUEUE_DEPTH];
        int unsigned    held;
        int unsigned    head;
        code_t          shown_code;
        logic [2:0]     phase;
        logic           kana;
        logic [3:0]     switches;
        logic [7:0]     data_byte;
        logic           strobe;
        logic           shift_flag;
        encoder_lines_t expected_lines[$];
        int unsigned    errors;

        function new();
            held       = 0;
            head       = 0;
            shown_code = '0;
            phase      = PH_POP;
            kana       = 1'b0;
            switches   = 4'hf;
            data_byte  = 8'h00;
            strobe     = 1'b0;
            shift_flag = 1'b0;
            errors     = 0;
        endfunction

        // fixed key tables, selected by kana mode and shift
        function code_t table_code(key_t key, logic kana_on, logic shift_on);
            code_t      c;
            logic [7:0] b;
            c = '0;
            b = 8'h00;
            // editing and cursor keys, bit 7 set in kana mode
            case (key)
                8'h08: c = 9'h008;  8'h09: c = 9'h009;  8'h0d: c = 9'h00a;
                8'h12: c = 9'h061;  8'h1b: c = 9'h01b;  8'h20: c = 9'h020;
                8'h24: c = 9'h063;  8'h25: c = 9'h175;  8'h26: c = 9'h066;
                8'h27: c = 9'h075;  8'h28: c = 9'h166;  8'h2d: c = 9'h064;
                8'h2e: c = 9'h164;
                default: c = '0;
            endcase
            if (c != '0) begin
                return kana_on ? (c | 9'h080) : c;
            end
            // numeric keypad, identical in every table
            if (key >= 8'h60 && key <= 8'h69) begin
                return {1'b0, key - 8'h30};
            end
            case (key)
                8'h6a, 8'h6b, 8'h6d, 8'h6e, 8'h6f: return {1'b0, key - 8'h40};
                default: ;
            endcase
            case ({kana_on, shift_on})
                2'b00: begin
                    case (key)
                        8'hba: b = 8'h3a;  8'hbb: b = 8'h3b;
                        8'hc0: b = 8'h40;  8'he2: b = 8'h5f;
                        default: begin
                            if ((key >= 8'h30 && key <= 8'h39) ||
                                (key >= 8'h41 && key <= 8'h5a)) begin
                                b = key;
                            end else if (key >= 8'hbc && key <= 8'hbf) begin
                                b = key - 8'h90;
                            end else if (key >= 8'hdb && key <= 8'hde) begin
                                b = key - 8'h80;
                            end
                        end
                    endcase
                end
                2'b01: begin
                    case (key)
                        8'hba: b = 8'h2a;  8'hbb: b = 8'h2b;  8'hbc: b = 8'h3c;
                        8'hbd: b = 8'h3d;  8'hbe: b = 8'h3e;  8'hbf: b = 8'h2f;
                        8'he2: b = 8'h5f;
                        default: begin
                            if (key >= 8'h31 && key <= 8'h39) begin
                                b = key - 8'h10;
                            end else if (key >= 8'h41 && key <= 8'h5a) begin
                                b = key;
                            end
                        end
                    endcase
                end
                2'b10: begin
                    case (key)
                        8'h30: b = 8'hdc;  8'h31: b = 8'hc7;  8'h32: b = 8'hcc;  8'h33: b = 8'hb1;
                        8'h34: b = 8'hb3;  8'h35: b = 8'hb4;  8'h36: b = 8'hb5;  8'h37: b = 8'hd4;
                        8'h38: b = 8'hd5;  8'h39: b = 8'hd6;
                        8'h41: b = 8'hc1;  8'h42: b = 8'hba;  8'h43: b = 8'hbf;  8'h44: b = 8'hbc;
                        8'h45: b = 8'hb2;  8'h46: b = 8'hca;  8'h47: b = 8'hb7;  8'h48: b = 8'hb8;
                        8'h49: b = 8'hc6;  8'h4a: b = 8'hcf;  8'h4b: b = 8'hc9;  8'h4c: b = 8'hd8;
                        8'h4d: b = 8'hd3;  8'h4e: b = 8'hd0;  8'h4f: b = 8'hd7;
                        8'h50: b = 8'hbe;  8'h51: b = 8'hc0;  8'h52: b = 8'hbd;  8'h53: b = 8'hc4;
                        8'h54: b = 8'hb6;  8'h55: b = 8'hc5;  8'h56: b = 8'hcb;  8'h57: b = 8'hc3;
                        8'h58: b = 8'hbb;  8'h59: b = 8'hdd;  8'h5a: b = 8'hc2;
                        8'hba: b = 8'hb9;  8'hbb: b = 8'hda;  8'hbc: b = 8'hc8;  8'hbd: b = 8'hce;
                        8'hbe: b = 8'hd9;  8'hbf: b = 8'hd2;  8'hc0: b = 8'hde;
                        8'hdb: b = 8'hdf;  8'hdc: b = 8'hb0;  8'hdd: b = 8'hd1;  8'hde: b = 8'hcd;
                        8'he2: b = 8'hdb;
                        default: b = 8'h00;
                    endcase
                end
                default: begin
                    case (key)
                        8'h30: b = 8'ha6;  8'h33: b = 8'ha7;  8'h34: b = 8'ha9;  8'h35: b = 8'haa;
                        8'h36: b = 8'hab;  8'h37: b = 8'hac;  8'h38: b = 8'had;  8'h39: b = 8'hae;
                        8'h45: b = 8'ha8;  8'h5a: b = 8'haf;
                        8'hbc: b = 8'ha4;  8'hbe: b = 8'ha1;  8'hbf: b = 8'ha5;
                        8'hdb: b = 8'ha2;  8'hdd: b = 8'ha3;
                        default: b = 8'h00;
                    endcase
                end
            endcase
            return {1'b0, b};
        endfunction

        // apply one accepted input beat and queue the lines it should produce
        function void note_key_event(action_t act, key_t key, logic shift_on, logic ctrl_on);
            encoder_lines_t want;
            code_t          code;
            want = '0;
            case (act)
                ACT_KEY_DOWN: begin
                    if (key == KEY_BREAK) begin
                        want.nmi = 1'b1;
                    end else if (key == KEY_CAPS) begin
                        kana = 1'b0;
                    end else if (key == KEY_KANA) begin
                        kana = !kana;
                    end else if (key >= KEY_F1 && key <= KEY_F4) begin
                        switches[key - KEY_F1] = 1'b0;
                    end else begin
                        // ctrl moves 0x40..0x5f up or down by 0x40, else table lookup
                        if (ctrl_on && key >= CTRL_LO && key <= CTRL_HI) begin
                            code = kana ? ({1'b0, key} + CTRL_OFS) : ({1'b0, key} - CTRL_OFS);
                        end else begin
                            code = table_code(key, kana, shift_on);
                        end
                        if (shift_on) begin
                            code = code | SHIFT_BIT;
                        end
                        if (code != '0) begin
                            if (held == QUEUE_DEPTH) begin
                                want.dropped = 1'b1;
                            end else begin
                                held_codes[(head + held) % QUEUE_DEPTH] = code;
                                held++;
                            end
                        end
                    end
                end
                ACT_KEY_UP: begin
                    if (key >= KEY_F1 && key <= KEY_F4) begin
                        switches[key - KEY_F1] = 1'b1;
                    end
                end
                ACT_TICK: begin
                    // six-phase frame sequence: pop, strobe high, strobe low, three quiet
                    case (phase)
                        PH_POP: begin
                            if (held == 0) begin
                                shown_code = '0;
                            end else begin
                                shown_code = held_codes[head];
                                head = (head + 1) % QUEUE_DEPTH;
                                held--;
                            end
                            if (shown_code != '0) begin
                                shift_flag = shown_code[8];
                                if (shown_code[7:0] != 8'h00) begin
                                    data_byte = shown_code[7:0];
                                end
                            end
                        end
                        PH_STB_HI: if (shown_code[7:0] != 8'h00) strobe = 1'b1;
                        PH_STB_LO: if (shown_code[7:0] != 8'h00) strobe = 1'b0;
                        default: ;
                    endcase
                    phase = (phase == PH_LAST) ? PH_POP : phase + 3'd1;
                end
                default: ;
            endcase
            want.switch_lines = switches;
            want.data_byte    = data_byte;
            want.strobe       = strobe;
            want.shift_line   = shift_flag;
            expected_lines.push_back(want);
        endfunction

        // compare one result beat against the oldest expectation
        function void check_lines(logic [M_DATA_W-1:0] beat);
            encoder_lines_t want;
            encoder_lines_t got;
            got = encoder_lines_t'(beat);
            if (expected_lines.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: result beat %h with nothing expected", $time, beat);
                end
                return;
            end
            want = expected_lines.pop_front();
            if (got.nmi !== want.nmi || got.switch_lines !== want.switch_lines ||
                got.data_byte !== want.data_byte || got.strobe !== want.strobe ||
                got.shift_line !== want.shift_line || got.dropped !== want.dropped) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch exp/act nmi %b/%b sw %h/%h data %h/%h stb %b/%b",
                             $time, want.nmi, got.nmi, want.switch_lines, got.switch_lines,
                             want.data_byte, got.data_byte, want.strobe, got.strobe);
                    $display("    exp/act shift %b/%b drop %b/%b",
                             want.shift_line, got.shift_line, want.dropped, got.dropped);
                end
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic [ACT_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_DATA_W-1:0]  m_tdata;

    key_encoder_scoreboard sb = new();
    int  stall_cycles = 0;
    bit  calm = 1'b0;
    bit  hold_off_req = 1'b0;

    keyboard_encoder_with_strobe u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // watch both channels: check results, note accepted beats, count quiet cycles
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_lines(m_tdata);
            end
            if (s_tvalid && s_tready) begin
                sb.note_key_event(action_t'(s_tuser), s_tdata[7:0], s_tdata[8], s_tdata[9]);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random backpressure, one long hold-off on request
    initial begin : receiver
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= !(!calm && $urandom_range(99) < IDLE_PCT);
                @(posedge aclk);
            end
        end
    end

    // offer one beat, with random idle cycles ahead of it, and wait for acceptance
    task automatic send_beat(action_t act, key_t key, logic shift_on, logic ctrl_on);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{(S_DATA_W-10){1'b0}}, ctrl_on, shift_on, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop offering until every expected result beat has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_lines.size() != 0) @(posedge aclk);
    endtask

    // mostly keys that translate, some specials, some anything
    function automatic key_t random_key();
        int unsigned pick;
        case ($urandom_range(9))
            0, 1: return key_t'($urandom_range(255));
            2, 3: return key_t'($urandom_range(8'h5a, 8'h41));
            4:    return key_t'($urandom_range(8'h39, 8'h30));
            5:    return key_t'($urandom_range(8'h6f, 8'h60));
            6:    return key_t'($urandom_range(8'hc0, 8'hba));
            7:    return key_t'($urandom_range(8'he2, 8'hdb));
            8:    return key_t'($urandom_range(8'h2e, 8'h08));
            default: begin
                pick = $urandom_range(6);
                if (pick == 0) return KEY_BREAK;
                if (pick == 1) return KEY_CAPS;
                if (pick == 2) return KEY_KANA;
                return KEY_F1 + key_t'(pick - 3);
            end
        endcase
    endfunction

    initial begin : stimulus
        int          r;
        int          tick_pct;
        action_t     act;
        key_t        key;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= ACT_NONE;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: pop from empty queue, unused action, switch lines, specials
        send_beat(ACT_TICK, 8'h00, 1'b0, 1'b0);
        send_beat(ACT_NONE, 8'hff, 1'b1, 1'b1);
        send_beat(ACT_KEY_DOWN, KEY_F1, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, KEY_F4, 1'b1, 1'b1);
        send_beat(ACT_KEY_UP, KEY_F1, 1'b0, 1'b0);
        send_beat(ACT_KEY_UP, 8'h41, 1'b0, 1'b0);
        send_beat(ACT_KEY_UP, KEY_F4, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, KEY_BREAK, 1'b0, 1'b0);
        // kana mode: ctrl offset up, shift-only code, kana letters
        send_beat(ACT_KEY_DOWN, KEY_KANA, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'h5a, 1'b0, 1'b1);
        send_beat(ACT_KEY_DOWN, 8'h41, 1'b1, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'h31, 1'b0, 1'b0);
        // back to plain: ctrl offset down, zero translations, fill to overflow
        send_beat(ACT_KEY_DOWN, KEY_CAPS, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'h5f, 1'b0, 1'b1);
        send_beat(ACT_KEY_DOWN, 8'h40, 1'b0, 1'b1);
        send_beat(ACT_KEY_DOWN, 8'h00, 1'b1, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'hff, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'he2, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'h39, 1'b1, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'h25, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'h60, 1'b0, 1'b0);
        send_beat(ACT_KEY_DOWN, 8'h20, 1'b1, 1'b1);
        wait_for_results();

        // random: tick density changes per block so the queue both fills and drains
        tick_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                tick_pct = $urandom_range(85, 25);
            end
            calm = (n >= 250 && n < 380);
            if (n == 150) begin
                hold_off_req = 1'b1;
            end
            if (n == 450) begin
                wait_for_results();
            end
            r = $urandom_range(99);
            if (r < tick_pct) begin
                act = ACT_TICK;
                key = key_t'($urandom_range(255));
            end else begin
                r = $urandom_range(19);
                if (r < 15) begin
                    act = ACT_KEY_DOWN;
                    key = random_key();
                end else if (r < 18) begin
                    act = ACT_KEY_UP;
                    key = random_key();
                end else begin
                    act = ACT_NONE;
                    key = key_t'($urandom_range(255));
                end
            end
            send_beat(act, key, 1'($urandom_range(1)), $urandom_range(3) == 0);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.expected_lines.size() != 0) begin
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
